// ===== design/mbh_pkg.sv =====
// ----------------------------------------------------------------------------
// mbh_pkg
// Shared constants and controller/datapath interface types for the
// MurmurHash2 byte hash unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mbh_pkg;

    // mixing multiplier and shift amounts
    localparam logic [31:0] MIX_MUL   = 32'h5bd1_e995;
    localparam int          SHIFT_K   = 24;
    localparam int          SHIFT_F1  = 13;
    localparam int          SHIFT_F2  = 15;

    // datapath operations
    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_ACCEPT = 3'd1;
    localparam logic [2:0] OP_K1     = 3'd2;
    localparam logic [2:0] OP_K2     = 3'd3;
    localparam logic [2:0] OP_FOLD   = 3'd4;
    localparam logic [2:0] OP_TAIL   = 3'd5;
    localparam logic [2:0] OP_FIN    = 3'd6;
    localparam logic [2:0] OP_OUT    = 3'd7;

    typedef struct packed {
        logic [2:0] op;
    } mbh_cmd_t;

    typedef struct packed {
        logic word_full;   // incoming byte completes a 32-bit word
        logic tail_after;  // leftover bytes held once the incoming item is taken
    } mbh_status_t;

endpackage

`default_nettype wire

// ===== design/mbh_datapath.sv =====
// ----------------------------------------------------------------------------
// mbh_datapath
// Hash, word gather and byte count registers around one shared 32-bit
// multiplier by the mixing constant; steps are chosen by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module mbh_datapath
    import mbh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire mbh_cmd_t    cmd,
    output mbh_status_t      status,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_byte_present,
    input  wire logic        s_first_of_key,
    input  wire logic [31:0] s_key_length,
    output logic [31:0]      m_hash_value
);

    logic [31:0] hash_reg,   hash_next;
    logic [31:0] gather_reg, gather_next;
    logic [1:0]  count_reg,  count_next;
    logic [31:0] prod_reg,   prod_next;
    logic [31:0] out_reg,    out_next;

    logic [31:0] base_hash;
    logic [31:0] base_gather;
    logic [1:0]  base_count;
    logic [31:0] ins_gather;
    logic [1:0]  ins_count;
    logic [31:0] mul_a;
    logic [31:0] mul_p;

    // a first item restarts the key before its own byte goes in
    always_comb begin
        base_hash   = s_first_of_key ? s_key_length : hash_reg;
        base_gather = s_first_of_key ? 32'd0 : gather_reg;
        base_count  = s_first_of_key ? 2'd0 : count_reg;
        if (s_byte_present) begin
            ins_gather = base_gather | ({24'd0, s_data_byte} << {base_count, 3'b000});
            ins_count  = base_count + 2'd1;
        end else begin
            ins_gather = base_gather;
            ins_count  = base_count;
        end
    end

    assign status.word_full  = s_byte_present && (base_count == 2'd3);
    assign status.tail_after = (ins_count != 2'd0);

    always_comb begin
        case (cmd.op)
            OP_K1:   mul_a = gather_reg;
            OP_K2:   mul_a = prod_reg ^ (prod_reg >> SHIFT_K);
            OP_FOLD: mul_a = hash_reg;
            OP_TAIL: mul_a = hash_reg ^ gather_reg;
            OP_FIN:  mul_a = hash_reg ^ (hash_reg >> SHIFT_F1);
            default: mul_a = hash_reg;
        endcase
    end

    assign mul_p = mul_a * MIX_MUL;

    always_comb begin
        hash_next   = hash_reg;
        gather_next = gather_reg;
        count_next  = count_reg;
        prod_next   = prod_reg;
        out_next    = out_reg;
        case (cmd.op)
            OP_ACCEPT: begin
                hash_next   = base_hash;
                gather_next = ins_gather;
                count_next  = ins_count;
            end
            OP_K1: begin
                prod_next = mul_p;
            end
            OP_K2: begin
                prod_next = mul_p;
            end
            OP_FOLD: begin
                hash_next   = mul_p ^ prod_reg;
                gather_next = 32'd0;
                count_next  = 2'd0;
            end
            OP_TAIL: begin
                hash_next = mul_p;
            end
            OP_FIN: begin
                hash_next = mul_p;
            end
            OP_OUT: begin
                out_next    = hash_reg ^ (hash_reg >> SHIFT_F2);
                hash_next   = 32'd0;
                gather_next = 32'd0;
                count_next  = 2'd0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg   <= 32'd0;
            gather_reg <= 32'd0;
            count_reg  <= 2'd0;
        end else begin
            hash_reg   <= hash_next;
            gather_reg <= gather_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

    assign m_hash_value = out_reg;

endmodule

`default_nettype wire

// ===== design/mbh_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbh_ctrl
// Sequencer for word mixing, tail fold and finish; owns the input ready
// and the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module mbh_ctrl
    import mbh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_last_of_key,
    output logic             m_valid,
    input  wire logic        m_ready,
    output mbh_cmd_t         cmd,
    input  wire mbh_status_t status
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_K1   = 3'd1;
    localparam logic [2:0] ST_K2   = 3'd2;
    localparam logic [2:0] ST_FOLD = 3'd3;
    localparam logic [2:0] ST_TAIL = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       last_reg,  last_next;
    logic       valid_reg, valid_next;

    always_comb begin
        state_next = state_reg;
        last_next  = last_reg;
        valid_next = valid_reg && !m_ready;
        cmd.op     = OP_NONE;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op    = OP_ACCEPT;
                    last_next = s_last_of_key;
                    if (status.word_full) begin
                        state_next = ST_K1;
                    end else if (s_last_of_key) begin
                        state_next = status.tail_after ? ST_TAIL : ST_FIN;
                    end
                end
            end
            ST_K1: begin
                cmd.op     = OP_K1;
                state_next = ST_K2;
            end
            ST_K2: begin
                cmd.op     = OP_K2;
                state_next = ST_FOLD;
            end
            ST_FOLD: begin
                // a full word leaves nothing over, so no tail fold after it
                cmd.op     = OP_FOLD;
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_TAIL: begin
                cmd.op     = OP_TAIL;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.op     = OP_FIN;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // wait for the result register to be free
                if (!valid_reg || m_ready) begin
                    cmd.op     = OP_OUT;
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
            valid_reg <= valid_next;
        end
    end

    assign m_valid = valid_reg;

endmodule

`default_nettype wire

// ===== design/murmur2_byte_hash_unit.sv =====
// ----------------------------------------------------------------------------
// murmur2_byte_hash_unit
// Streaming 32-bit MurmurHash2 (seed 0) over key bytes, at most one byte per transfer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  s_      | in        | s_valid/s_ready  | data_byte, byte_present, first/last, key_length
//  m_      | out       | m_valid/m_ready  | hash_value
//
//  a byte that does not complete a word keeps the unit ready; one that
//  completes a word runs K1, K2 and FOLD (two mix multiplies and the fold
//  share one 32x32 multiplier); the last transfer of a key adds FIN, with
//  TAIL before it for leftover bytes, then loads the result register once free
//  aresetn clears hash state, sequencer and result valid
//  a waiting result does not block new transfers for the next key
// ----------------------------------------------------------------------------
`default_nettype none

module murmur2_byte_hash_unit
    import mbh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_byte_present,
    input  wire logic        s_first_of_key,
    input  wire logic        s_last_of_key,
    input  wire logic [31:0] s_key_length,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_hash_value
);

    mbh_cmd_t    cmd;
    mbh_status_t status;

    mbh_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_last_of_key (s_last_of_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .cmd           (cmd),
        .status        (status)
    );

    mbh_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_data_byte    (s_data_byte),
        .s_byte_present (s_byte_present),
        .s_first_of_key (s_first_of_key),
        .s_key_length   (s_key_length),
        .m_hash_value   (m_hash_value)
    );

`ifndef SYNTHESIS
    // a partial-word byte that ends nothing keeps the unit ready
    a_short_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_last_of_key && !status.word_full) |=> s_ready)
        else $error("ready dropped after a partial-word transfer");

    // a completed word keeps the unit busy with mixing
    a_word_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && status.word_full) |=> !s_ready)
        else $error("new transfer taken during word mixing");

    // the result register is never overwritten while a result is held
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_OUT) |-> (!m_valid || m_ready))
        else $error("result loaded over an untaken result");

    // input ready only when the datapath is not mid-sequence
    a_ready_op: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (cmd.op == OP_NONE || cmd.op == OP_ACCEPT))
        else $error("ready raised during a datapath step");
`endif

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams keys byte by byte into the MurmurHash2 byte hash unit with random
// gaps on both channels and compares every hash against a running software
// copy of the hash state kept per key.
// ----------------------------------------------------------------------------

module testbench;
    import mbh_pkg::*;

    class hash_tracker;
        logic [31:0]  running_hash;
        logic [31:0]  word_gather;
        int unsigned  bytes_in_word;
        logic [31:0]  expected_hashes[$];
        int unsigned  mismatches;
        int unsigned  hashes_checked;

        function new();
            clear_key();
            mismatches = 0;
            hashes_checked = 0;
        endfunction

        function void clear_key();
            running_hash = '0;
            word_gather = '0;
            bytes_in_word = 0;
        endfunction

        // follow one accepted input transfer, queue a hash on the last one
        function void note_transfer(logic [7:0] data_byte, logic present, logic first,
                                    logic last, logic [31:0] key_len);
            logic [31:0] k;
            logic [31:0] h;
            if (first) begin
                clear_key();
                running_hash = key_len;
            end
            if (present) begin
                word_gather |= 32'(data_byte) << (8 * bytes_in_word);
                bytes_in_word++;
                if (bytes_in_word == 4) begin
                    k = word_gather * MIX_MUL;
                    k ^= k >> SHIFT_K;
                    k = k * MIX_MUL;
                    running_hash = (running_hash * MIX_MUL) ^ k;
                    word_gather = '0;
                    bytes_in_word = 0;
                end
            end
            if (last) begin
                h = running_hash;
                if (bytes_in_word != 0) begin
                    h ^= word_gather;
                    h = h * MIX_MUL;
                end
                h ^= h >> SHIFT_F1;
                h = h * MIX_MUL;
                h ^= h >> SHIFT_F2;
                expected_hashes.push_back(h);
                clear_key();
            end
        endfunction

        function void check_hash(logic [31:0] actual);
            logic [31:0] expected;
            if (expected_hashes.size() == 0) begin
                $error("hash_value: unexpected transfer, expected none, actual %08h", actual);
                mismatches++;
            end else begin
                expected = expected_hashes.pop_front();
                hashes_checked++;
                if (actual !== expected) begin
                    $error("hash_value: expected %08h, actual %08h", expected, actual);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        s_byte_present = 1'b0;
    logic        s_first_of_key = 1'b0;
    logic        s_last_of_key = 1'b0;
    logic [31:0] s_key_length = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_hash_value;

    hash_tracker tracker = new();
    int unsigned transfers_in = 0;
    int unsigned keys_closed = 0;
    bit          send_quiet = 1'b0;
    bit          recv_quiet = 1'b0;

    murmur2_byte_hash_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_byte_present (s_byte_present),
        .s_first_of_key (s_first_of_key),
        .s_last_of_key  (s_last_of_key),
        .s_key_length   (s_key_length),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hash_value   (m_hash_value)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // one input transfer, with a random gap in front of it
    task automatic send_item(input logic [7:0] data_byte, input logic present,
                             input logic first, input logic last,
                             input logic [31:0] key_len);
        int gap;
        if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
        gap = send_quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_data_byte    <= data_byte;
        s_byte_present <= present;
        s_first_of_key <= first;
        s_last_of_key  <= last;
        s_key_length   <= key_len;
        do @(posedge aclk); while (!s_ready);
        tracker.note_transfer(data_byte, present, first, last, key_len);
        transfers_in++;
        if (last) keys_closed++;
    endtask

    // a key of nbytes bytes; optional empty items in between and an empty closing item
    task automatic send_key(input int unsigned nbytes, input bit with_first,
                            input logic [31:0] key_len, input int unsigned hole_pct,
                            input bit empty_tail);
        bit pending_first;
        bit last_here;
        pending_first = with_first;
        for (int unsigned i = 0; i < nbytes; i++) begin
            if (hole_pct != 0 && $urandom_range(0, 99) < hole_pct) begin
                send_item(8'($urandom), 1'b0, pending_first, 1'b0, key_len);
                pending_first = 1'b0;
            end
            last_here = (i == nbytes - 1) && !empty_tail;
            send_item(8'($urandom), 1'b1, pending_first, last_here, key_len);
            pending_first = 1'b0;
        end
        if (nbytes == 0 || empty_tail)
            send_item(8'($urandom), 1'b0, pending_first, 1'b1, key_len);
    endtask

    // result side: random stall before each transfer
    initial begin
        int stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if ($urandom_range(0, 29) == 0) recv_quiet = !recv_quiet;
            stall = recv_quiet ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            tracker.check_hash(m_hash_value);
        end
    end

    initial begin
        int unsigned directed_count;
        int unsigned pick;
        int unsigned nbytes;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty key, byte extremes, word boundaries, odd cases
        send_key(0, 1'b1, 32'd0, 0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1, 1'b1, 32'd1);
        send_item(8'hff, 1'b1, 1'b1, 1'b1, 32'hffff_ffff);
        send_key(3, 1'b1, 32'd3, 0, 1'b0);
        send_key(4, 1'b1, 32'd4, 0, 1'b0);
        send_key(5, 1'b1, 32'd5, 50, 1'b0);
        send_key(2, 1'b0, 32'd0, 0, 1'b0);
        send_key(2, 1'b1, 32'd2, 0, 1'b1);
        send_key(3, 1'b1, 32'h8000_0001, 0, 1'b0);
        directed_count = transfers_in;

        while (transfers_in - directed_count < 700) begin
            pick = $urandom_range(0, 99);
            nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(0, 12);
            if (pick < 70) begin
                send_key(nbytes, 1'b1, nbytes, 0, 1'b0);
            end else if (pick < 82) begin
                send_key(nbytes, 1'b1, $urandom, 20, 1'b0);
            end else if (pick < 89) begin
                send_key(nbytes, 1'b0, $urandom, 10, 1'b0);
            end else if (pick < 94) begin
                send_key(nbytes, 1'b1, nbytes, 0, 1'b1);
            end else begin
                // stray transfers without first or last, left for the next key
                repeat ($urandom_range(1, 6))
                    send_item(8'($urandom), 1'($urandom), 1'b0, 1'b0, $urandom);
            end
        end
        s_valid <= 1'b0;

        while (tracker.expected_hashes.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d input transfers and %0d keys, %0d hashes compared",
                 transfers_in, keys_closed, tracker.hashes_checked);
        if (tracker.mismatches == 0 && tracker.expected_hashes.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
